// File: rtl/ffpa_pkg.sv
// shared constants and codes for the first-fit page allocator
// no dependencies; used by the core and its port checker
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;

	localparam int MAX_PAGES_DEF = 256;
	localparam int PTR_W = 9;
	localparam int TAG_W = 8;

	// request kinds
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_CHECK = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NOMEM   = 3'd2;
	localparam logic [2:0] ST_NORUN   = 3'd3;
	localparam logic [2:0] ST_UNALLOC = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
	localparam logic [1:0] CFG_PAGE_SHIFT = 2'd1;
	localparam logic [1:0] CFG_POOL_SIZE  = 2'd2;

	// configuration reset values
	localparam logic [31:0] HEAP_BASE_RST  = 32'd0;
	localparam logic [4:0]  PAGE_SHIFT_RST = 5'd12;
	localparam logic [8:0]  POOL_SIZE_RST  = 9'd256;

	localparam logic [4:0] SHIFT_MIN = 5'd4;
	localparam logic [4:0] SHIFT_MAX = 5'd16;

endpackage
`default_nettype wire

// File: rtl/first_fit_page_allocator_core.sv
// first-fit page allocator core: page tag store, request sequencer, result register
// depends on ffpa_pkg; checked by ffpa_checker (bound in its own file)
//
// usage:
// requests enter on in_valid/in_ready with req_type, length and address; each
// request yields exactly one result on out_valid/out_ready. configuration is
// written on cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data.
// a request passes the decode states DEC1, DEC2 and DEC3, then a walk over the
// tag store at one entry per cycle through its single read port: allocate
// reads from page 0 until a long enough free run is found and then writes one
// page of the run per cycle; check and free read their range, free writing each
// page back behind the read. rejected requests skip the walk.
// after reset the store is cleared, one entry per cycle over all MAX_PAGES
// entries, while in_ready stays low. the result sits in an output register: a
// new request is taken while it waits, and a finished request holds in its
// response step until the receiver takes the previous result.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_page_allocator_core #(
	parameter int MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] length,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       page_index,
	output logic [7:0]       owner_tag,
	output logic             double_free,
	output logic [8:0]       pages_in_use
);

	localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PW = ffpa_pkg::PTR_W;
	localparam int TW = ffpa_pkg::TAG_W;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DEC1  = 8'b0000_0100,
		S_DEC2  = 8'b0000_1000,
		S_DEC3  = 8'b0001_0000,
		S_SCAN  = 8'b0010_0000,
		S_MARK  = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] heap_base_q;
	logic [4:0]  page_shift_q;
	logic [8:0]  pool_size_q;

	// persistent state
	logic [8:0]    used_q;
	logic [TW-1:0] next_tag_q;
	logic [IW-1:0] clr_ptr_q;

	// request and decode registers
	logic [1:0]  req_q;
	logic [31:0] len_q;
	logic [31:0] addr_q;
	logic [4:0]  sh_q;
	logic [8:0]  pt_q;
	logic [31:0] off_q;
	logic [32:0] lim_q;
	logic [32:0] nsum_q;
	logic        low_bad_q;
	logic        high_bad_q;
	logic [8:0]  start_q;
	logic [9:0]  n_q;
	logic [9:0]  need_q;
	logic [8:0]  free_cnt_q;

	// walk registers
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] end_q;
	logic          rd_v_s1;
	logic [PW-1:0] rd_a_s1;
	logic [8:0]    run_q;
	logic [8:0]    cleared_q;
	logic          flag_q;
	logic [PW-1:0] mark_ptr_q;
	logic [PW-1:0] mark_end_q;

	// pending result
	logic [2:0]    res_status_q;
	logic [7:0]    res_idx_q;
	logic [TW-1:0] res_tag_q;
	logic          res_df_q;

	// tag store
	logic [TW-1:0] mem [MAX_PAGES];
	logic [TW-1:0] rdata;
	logic          we;
	logic [IW-1:0] wa;
	logic [TW-1:0] wd;
	logic [IW-1:0] ra;

	// effective configuration
	logic [4:0]  eff_sh;
	logic [8:0]  eff_pt;
	logic [32:0] eff_mask;

	always_comb begin
		if (page_shift_q < ffpa_pkg::SHIFT_MIN) begin
			eff_sh = ffpa_pkg::SHIFT_MIN;
		end else if (page_shift_q > ffpa_pkg::SHIFT_MAX) begin
			eff_sh = ffpa_pkg::SHIFT_MAX;
		end else begin
			eff_sh = page_shift_q;
		end
		if (32'(pool_size_q) > 32'(MAX_PAGES)) begin
			eff_pt = 9'(MAX_PAGES);
		end else begin
			eff_pt = pool_size_q;
		end
		eff_mask = (33'd1 << eff_sh) - 33'd1;
	end

	// decode stage 2 values
	logic [31:0] nraw;
	logic        unal;
	logic [32:0] need_full;
	logic [31:0] sh_mask;

	always_comb begin
		sh_mask   = (32'd1 << sh_q) - 32'd1;
		nraw      = len_q >> sh_q;
		unal      = |(off_q & sh_mask);
		need_full = nsum_q >> sh_q;
	end

	// decode stage 3 values
	logic [10:0]   end_sum;
	logic [PW-1:0] end_clamp;

	always_comb begin
		end_sum = {2'b00, start_q} + {1'b0, n_q};
		if (end_sum > {2'b00, pt_q}) begin
			end_clamp = pt_q;
		end else begin
			end_clamp = PW'(end_sum);
		end
	end

	// walk values
	logic [8:0] run_nx;
	logic       run_hit;

	always_comb begin
		run_nx  = run_q + 9'd1;
		run_hit = ({1'b0, run_nx} >= need_q);
	end

	logic out_free;
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// store port control
	always_comb begin
		we = 1'b0;
		wa = clr_ptr_q;
		wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_ptr_q;
			end
			S_SCAN: begin
				if (rd_v_s1 && (req_q == ffpa_pkg::REQ_FREE)) begin
					we = 1'b1;
					wa = IW'(rd_a_s1);
				end
			end
			S_MARK: begin
				we = 1'b1;
				wa = IW'(mark_ptr_q);
				wd = next_tag_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
		ra = IW'(rd_ptr_q);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata <= mem[ra];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= ffpa_pkg::HEAP_BASE_RST;
			page_shift_q <= ffpa_pkg::PAGE_SHIFT_RST;
			pool_size_q  <= ffpa_pkg::POOL_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ffpa_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				ffpa_pkg::CFG_PAGE_SHIFT: page_shift_q <= cfg_data[4:0];
				ffpa_pkg::CFG_POOL_SIZE:  pool_size_q  <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_ptr_q  <= '0;
			used_q     <= '0;
			next_tag_q <= TW'(1);
			rd_v_s1    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + IW'(1);
					if (clr_ptr_q == IW'(MAX_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC1;
					end
				end
				S_DEC1: state_q <= S_DEC2;
				S_DEC2: state_q <= S_DEC3;
				S_DEC3: begin
					state_q <= S_RESP;
					if (req_q == ffpa_pkg::REQ_ALLOC) begin
						if (len_q != 32'd0 && need_q <= {1'b0, free_cnt_q}) begin
							state_q <= S_SCAN;
						end
					end else if (req_q == ffpa_pkg::REQ_CHECK
							|| req_q == ffpa_pkg::REQ_FREE) begin
						if (len_q != 32'd0 && !low_bad_q && !high_bad_q
								&& end_clamp != start_q) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_ptr_q != end_q) begin
						rd_v_s1 <= 1'b1;
					end
					if (rd_v_s1 && req_q == ffpa_pkg::REQ_ALLOC && rdata == '0 && run_hit) begin
						rd_v_s1 <= 1'b0;
						state_q <= S_MARK;
					end else if (rd_ptr_q == end_q && !rd_v_s1) begin
						state_q <= S_RESP;
						if (req_q == ffpa_pkg::REQ_FREE) begin
							used_q <= (used_q > cleared_q) ? used_q - cleared_q : 9'd0;
						end
					end
				end
				S_MARK: begin
					if (mark_ptr_q + PW'(1) == mark_end_q) begin
						state_q <= S_RESP;
						used_q  <= used_q + 9'(need_q);
						if (next_tag_q + TW'(1) == '0) begin
							next_tag_q <= TW'(1);
						end else begin
							next_tag_q <= next_tag_q + TW'(1);
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload and datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q  <= req_type;
				len_q  <= length;
				addr_q <= address;
			end
			S_DEC1: begin
				sh_q      <= eff_sh;
				pt_q      <= eff_pt;
				off_q     <= addr_q - heap_base_q;
				lim_q     <= {1'b0, heap_base_q} + (33'(eff_pt) << eff_sh);
				nsum_q    <= {1'b0, len_q} + eff_mask;
				low_bad_q <= (addr_q < heap_base_q);
			end
			S_DEC2: begin
				high_bad_q <= ({1'b0, addr_q} >= lim_q);
				start_q    <= 9'(off_q >> sh_q);
				n_q        <= (nraw > 32'd511) ? 10'd512 : 10'(nraw) + 10'(unal);
				need_q     <= (need_full > 33'd511) ? 10'd512 : 10'(need_full);
				free_cnt_q <= (pt_q > used_q) ? pt_q - used_q : 9'd0;
			end
			S_DEC3: begin
				res_idx_q    <= '0;
				res_tag_q    <= '0;
				res_df_q     <= 1'b0;
				run_q        <= '0;
				cleared_q    <= '0;
				flag_q       <= 1'b0;
				res_status_q <= ffpa_pkg::ST_INVALID;
				if (req_q == ffpa_pkg::REQ_ALLOC) begin
					rd_ptr_q <= '0;
					end_q    <= pt_q;
					if (len_q != 32'd0 && need_q > {1'b0, free_cnt_q}) begin
						res_status_q <= ffpa_pkg::ST_NOMEM;
					end
				end else begin
					rd_ptr_q <= start_q;
					end_q    <= end_clamp;
					if ((req_q == ffpa_pkg::REQ_CHECK || req_q == ffpa_pkg::REQ_FREE)
							&& len_q != 32'd0 && !low_bad_q && !high_bad_q) begin
						res_status_q <= ffpa_pkg::ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (rd_ptr_q != end_q) begin
					rd_ptr_q <= rd_ptr_q + PW'(1);
				end
				rd_a_s1 <= rd_ptr_q;
				if (rd_v_s1) begin
					case (req_q)
						ffpa_pkg::REQ_ALLOC: begin
							if (rdata != '0) begin
								run_q <= '0;
							end else begin
								run_q <= run_nx;
								if (run_hit) begin
									mark_ptr_q <= rd_a_s1 - run_q;
									mark_end_q <= rd_a_s1 + PW'(1);
								end
							end
						end
						ffpa_pkg::REQ_CHECK: begin
							if (rdata == '0) begin
								flag_q <= 1'b1;
							end
						end
						default: begin
							if (rdata == '0) begin
								flag_q <= 1'b1;
							end else begin
								cleared_q <= cleared_q + 9'd1;
							end
						end
					endcase
				end else if (rd_ptr_q == end_q) begin
					case (req_q)
						ffpa_pkg::REQ_ALLOC: res_status_q <= ffpa_pkg::ST_NORUN;
						ffpa_pkg::REQ_CHECK: begin
							if (flag_q) begin
								res_status_q <= ffpa_pkg::ST_UNALLOC;
							end
						end
						default: res_df_q <= flag_q;
					endcase
				end
			end
			S_MARK: begin
				mark_ptr_q <= mark_ptr_q + PW'(1);
				if (mark_ptr_q + PW'(1) == mark_end_q) begin
					res_status_q <= ffpa_pkg::ST_OK;
					res_idx_q    <= 8'(mark_end_q - PW'(need_q));
					res_tag_q    <= next_tag_q;
				end
			end
			S_RESP: begin
				if (out_free) begin
					status       <= res_status_q;
					page_index   <= res_idx_q;
					owner_tag    <= res_tag_q;
					double_free  <= res_df_q;
					pages_in_use <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/ffpa_checker.sv
// port-level checker for the first-fit page allocator core, with its bind
// depends on ffpa_pkg and first_fit_page_allocator_core
`timescale 1ns / 1ps
`default_nettype none
module ffpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [7:0]  page_index,
	input wire logic [7:0]  owner_tag,
	input wire logic        double_free,
	input wire logic [8:0]  pages_in_use
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(page_index) && $stable(owner_tag)
			&& $stable(double_free) && $stable(pages_in_use))
		else $error("result changed while stalled");

	// no placement reported on a failed request
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffpa_pkg::ST_OK |-> owner_tag == 8'd0 && page_index == 8'd0)
		else $error("failed request reports a placement");

	// double free only on a successful request with no tag
	a_df_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && double_free |-> status == ffpa_pkg::ST_OK && owner_tag == 8'd0)
		else $error("double free flag on a wrong result");

	// a request accepted with no result pending is not answered in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind first_fit_page_allocator_core ffpa_checker u_ffpa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.page_index(page_index),
	.owner_tag(owner_tag),
	.double_free(double_free),
	.pages_in_use(pages_in_use)
);
`default_nettype wire
